[sv/fixed_block_pool_allocator_defines.svh]
// Assertion helpers for the allocator RTL
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define FBPA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high
`define FBPA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/fbpa_pkg.sv]
package fbpa_pkg;

   localparam int CNT_W = 11;
   localparam int IDX_W = 10;

   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [IDX_W-1:0] idx_type;

   typedef enum logic {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_FULL  = 2'd3
   } status_type;

endpackage

[sv/fixed_block_pool_allocator.sv]
// Fixed-size block allocator handing out block indices from a free list held in an
// on-chip next-index RAM. Pulse start while busy is low to issue one transaction;
// its result appears on the rsp_ ports for exactly one cycle, flagged by rsp_valid,
// and there is no way to hold it off, so sample it when rsp_valid is high. For a
// free the result shows in the cycle after start and another transaction may be
// issued straight away. An allocate first enters a pop state, because the
// successor of the list head comes out of the registered RAM read port in the
// cycle after the address; busy is high in the pop state and the result follows it.
// Writing csr_wdata with csr_we reinitialises the pool; do so only when no
// transaction is outstanding. The list is linked lazily, so no clearing pass is
// needed after reset.
module fixed_block_pool_allocator #(
   parameter int MAX_BLOCKS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  fbpa_pkg::func_type     req_func,
   input  fbpa_pkg::idx_type      req_block_index,
   output logic                   rsp_valid,
   output fbpa_pkg::status_type   rsp_status,
   output fbpa_pkg::idx_type      rsp_alloc_index,
   output fbpa_pkg::cnt_type      rsp_free_count,
   input  logic                   csr_we,
   input  fbpa_pkg::cnt_type      csr_wdata
);
   import fbpa_pkg::*;
   `include "fixed_block_pool_allocator_defines.svh"

   localparam int AW = $clog2(MAX_BLOCKS);
   localparam int RESET_COUNT = (MAX_BLOCKS < 1024) ? MAX_BLOCKS : 1024;

   typedef enum logic {
      ST_IDLE,
      ST_POP
   } state_type;

   function automatic cnt_type clamp_count(cnt_type v);
      cnt_type r;
      r = v;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (int'(v) > MAX_BLOCKS) begin
         r = CNT_W'(MAX_BLOCKS);
      end
      return r;
   endfunction

   function automatic logic [AW-1:0] to_addr(cnt_type v);
      return AW'(v);
   endfunction

   state_type  state_ff, state_in;
   cnt_type    count_ff, count_in;
   cnt_type    head_ff, head_in;
   cnt_type    free_ff, free_in;
   cnt_type    init_ff, init_in;
   logic       fwd_ff, fwd_in;
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   idx_type    rsp_alloc_ff, rsp_alloc_in;
   cnt_type    rsp_free_ff, rsp_free_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   cnt_type       mem_wdata;
   cnt_type       mem_rdata;
   cnt_type       succ;
   cnt_type       free_dec;
   cnt_type       idx_ext;

   fbpa_ram #(
      .DEPTH (MAX_BLOCKS),
      .AW    (AW)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (to_addr(head_ff)),
      .rd_data (mem_rdata)
   );

   // the lazy link written in the accept cycle may target the head itself
   assign succ     = fwd_ff ? init_ff : mem_rdata;
   assign free_dec = free_ff - CNT_W'(1);
   assign idx_ext  = CNT_W'(req_block_index);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      free_in       = free_ff;
      init_in       = init_ff;
      fwd_in        = fwd_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_alloc_in  = rsp_alloc_ff;
      rsp_free_in   = rsp_free_ff;
      mem_we        = 1'b0;
      mem_waddr     = to_addr(init_ff);
      mem_wdata     = init_ff + CNT_W'(1);

      if (csr_we) begin
         count_in = clamp_count(csr_wdata);
         head_in  = '0;
         free_in  = clamp_count(csr_wdata);
         init_in  = '0;
         state_in = ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  if (req_func == FUNC_ALLOC) begin
                     fwd_in = 1'b0;
                     if (init_ff < count_ff) begin
                        mem_we  = 1'b1;
                        init_in = init_ff + CNT_W'(1);
                        fwd_in  = (init_ff == head_ff);
                     end
                     state_in = ST_POP;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_alloc_in = '0;
                     if (idx_ext >= count_ff) begin
                        rsp_status_in = STATUS_RANGE;
                        rsp_free_in   = free_ff;
                     end else if (free_ff >= count_ff) begin
                        rsp_status_in = STATUS_FULL;
                        rsp_free_in   = free_ff;
                     end else begin
                        mem_we        = 1'b1;
                        mem_waddr     = to_addr(idx_ext);
                        mem_wdata     = (free_ff == '0) ? count_ff : head_ff;
                        head_in       = idx_ext;
                        free_in       = free_ff + CNT_W'(1);
                        rsp_status_in = STATUS_OK;
                        rsp_free_in   = free_ff + CNT_W'(1);
                     end
                  end
               end
            end
            ST_POP: begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (free_ff != '0) begin
                  rsp_status_in = STATUS_OK;
                  rsp_alloc_in  = head_ff[IDX_W-1:0];
                  free_in       = free_dec;
                  rsp_free_in   = free_dec;
                  if (free_dec == '0) begin
                     head_in = '0;
                  end else begin
                     // a successor past the end follows a free of a block never handed out
                     head_in = (succ < count_ff) ? succ : '0;
                  end
               end else begin
                  rsp_status_in = STATUS_EMPTY;
                  rsp_alloc_in  = '0;
                  rsp_free_in   = free_ff;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= CNT_W'(RESET_COUNT);
         head_ff      <= '0;
         free_ff      <= CNT_W'(RESET_COUNT);
         init_ff      <= '0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         init_ff      <= init_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_alloc_ff  <= rsp_alloc_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign busy            = (state_ff == ST_POP);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_alloc_index = rsp_alloc_ff;
   assign rsp_free_count  = rsp_free_ff;

   `FBPA_ASSERT_NOW(a_free_within_count, clock, reset, 1'b1, free_ff <= count_ff, "free count above block count")
   `FBPA_ASSERT_NOW(a_init_within_count, clock, reset, 1'b1, init_ff <= count_ff, "lazy link pointer past block count")
   `FBPA_ASSERT_NOW(a_head_in_range, clock, reset, free_ff != '0, head_ff < count_ff, "list head outside pool")
   `FBPA_ASSERT_NEXT(a_alloc_goes_busy, clock, reset, start && !busy && !csr_we && req_func == FUNC_ALLOC, busy, "allocate did not enter pop cycle")
   `FBPA_ASSERT_NEXT(a_pop_answers, clock, reset, state_ff == ST_POP && !csr_we, rsp_valid, "pop cycle gave no result")

endmodule

[sv/fbpa_ram.sv]
module fbpa_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  fbpa_pkg::cnt_type       wr_data,
   input  logic [AW-1:0]           rd_addr,
   output fbpa_pkg::cnt_type       rd_data
);
   import fbpa_pkg::*;

   cnt_type mem [DEPTH];
   cnt_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[verif/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fbpa_pkg::*;

   localparam int POOL_MAX = 1024;
   // cycles with no transaction on either side before the run is abandoned
   localparam int STALL_LIMIT = 500;

   typedef struct packed {
      status_type status;
      idx_type    alloc_index;
      cnt_type    free_count;
   } pool_result_type;

   typedef enum logic {
      ROW_OP  = 1'b0,
      ROW_CSR = 1'b1
   } row_kind_type;

   // typed = 1: the expected result is the one written in the row
   typedef struct packed {
      row_kind_type kind;
      func_type     func;
      idx_type      index;
      cnt_type      csr_value;
      logic         typed;
      status_type   status;
      idx_type      alloc_index;
      cnt_type      free_count;
   } row_type;

   localparam int NUM_ROWS = 30;
   localparam row_type DIRECTED_OPS [NUM_ROWS] = '{
      // reset pool of 1024 blocks
      '{ROW_OP,  FUNC_ALLOC, 10'd0,    11'd0,    1'b1, STATUS_OK,    10'd0,    11'd1023},
      '{ROW_OP,  FUNC_ALLOC, 10'd1023, 11'd0,    1'b1, STATUS_OK,    10'd1,    11'd1022},
      '{ROW_OP,  FUNC_FREE,  10'd1023, 11'd0,    1'b1, STATUS_OK,    10'd0,    11'd1023},
      '{ROW_OP,  FUNC_ALLOC, 10'd0,    11'd0,    1'b1, STATUS_OK,    10'd1023, 11'd1022},
      '{ROW_OP,  FUNC_ALLOC, 10'd0,    11'd0,    1'b0, STATUS_OK,    10'd0,    11'd0},
      '{ROW_OP,  FUNC_FREE,  10'd0,    11'd0,    1'b0, STATUS_OK,    10'd0,    11'd0},
      // oversized count saturates to the full pool
      '{ROW_CSR, FUNC_ALLOC, 10'd0,    11'd2047, 1'b0, STATUS_OK,    10'd0,    11'd0},
      '{ROW_OP,  FUNC_FREE,  10'd5,    11'd0,    1'b1, STATUS_FULL,  10'd0,    11'd1024},
      '{ROW_OP,  FUNC_FREE,  10'd1023, 11'd0,    1'b1, STATUS_FULL,  10'd0,    11'd1024},
      '{ROW_CSR, FUNC_ALLOC, 10'd0,    11'd1,    1'b0, STATUS_OK,    10'd0,    11'd0},
      '{ROW_OP,  FUNC_FREE,  10'd0,    11'd0,    1'b1, STATUS_FULL,  10'd0,    11'd1},
      // range check wins over capacity check
      '{ROW_OP,  FUNC_FREE,  10'd1023, 11'd0,    1'b1, STATUS_RANGE, 10'd0,    11'd1},
      '{ROW_OP,  FUNC_ALLOC, 10'd0,    11'd0,    1'b1, STATUS_OK,    10'd0,    11'd0},
      '{ROW_OP,  FUNC_ALLOC, 10'd0,    11'd0,    1'b1, STATUS_EMPTY, 10'd0,    11'd0},
      '{ROW_OP,  FUNC_FREE,  10'd1,    11'd0,    1'b1, STATUS_RANGE, 10'd0,    11'd0},
      // push onto an empty list links to the end mark
      '{ROW_OP,  FUNC_FREE,  10'd0,    11'd0,    1'b1, STATUS_OK,    10'd0,    11'd1},
      '{ROW_OP,  FUNC_ALLOC, 10'd0,    11'd0,    1'b1, STATUS_OK,    10'd0,    11'd0},
      // zero count reads as one
      '{ROW_CSR, FUNC_ALLOC, 10'd0,    11'd0,    1'b0, STATUS_OK,    10'd0,    11'd0},
      '{ROW_OP,  FUNC_ALLOC, 10'd0,    11'd0,    1'b1, STATUS_OK,    10'd0,    11'd0},
      '{ROW_OP,  FUNC_ALLOC, 10'd0,    11'd0,    1'b1, STATUS_EMPTY, 10'd0,    11'd0},
      // freeing a block not yet handed out leaves a successor past the end
      '{ROW_CSR, FUNC_ALLOC, 10'd0,    11'd2,    1'b0, STATUS_OK,    10'd0,    11'd0},
      '{ROW_OP,  FUNC_ALLOC, 10'd0,    11'd0,    1'b1, STATUS_OK,    10'd0,    11'd1},
      '{ROW_OP,  FUNC_FREE,  10'd1,    11'd0,    1'b1, STATUS_OK,    10'd0,    11'd2},
      '{ROW_OP,  FUNC_ALLOC, 10'd0,    11'd0,    1'b1, STATUS_OK,    10'd1,    11'd1},
      '{ROW_OP,  FUNC_ALLOC, 10'd0,    11'd0,    1'b1, STATUS_OK,    10'd0,    11'd0},
      '{ROW_OP,  FUNC_ALLOC, 10'd0,    11'd0,    1'b1, STATUS_EMPTY, 10'd0,    11'd0},
      '{ROW_CSR, FUNC_ALLOC, 10'd0,    11'd1025, 1'b0, STATUS_OK,    10'd0,    11'd0},
      '{ROW_OP,  FUNC_ALLOC, 10'd0,    11'd0,    1'b1, STATUS_OK,    10'd0,    11'd1023},
      '{ROW_OP,  FUNC_FREE,  10'd682,  11'd0,    1'b0, STATUS_OK,    10'd0,    11'd0},
      '{ROW_OP,  FUNC_FREE,  10'd341,  11'd0,    1'b0, STATUS_OK,    10'd0,    11'd0}
   };

   logic       clock;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   func_type   req_func = FUNC_ALLOC;
   idx_type    req_block_index = '0;
   logic       rsp_valid;
   status_type rsp_status;
   idx_type    rsp_alloc_index;
   cnt_type    rsp_free_count;
   logic       csr_we = 1'b0;
   cnt_type    csr_wdata = '0;

   fixed_block_pool_allocator #(.MAX_BLOCKS(POOL_MAX)) DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_block_index (req_block_index),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_alloc_index (rsp_alloc_index),
      .rsp_free_count  (rsp_free_count),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // shadow of the pool
   cnt_type pool_next [POOL_MAX] = '{default: '0};
   idx_type pool_head   = '0;
   cnt_type pool_free   = 11'd1024;
   cnt_type pool_linked = '0;
   cnt_type pool_size   = 11'd1024;

   pool_result_type results_due [$];
   idx_type         held_blocks [$];
   int unsigned     mismatches = 0;
   int unsigned     quiet_cycles = 0;
   logic            no_gaps = 1'b0;

   function automatic pool_result_type pool_apply(input func_type func, input idx_type index);
      pool_result_type res;
      cnt_type         succ;
      res.status      = STATUS_OK;
      res.alloc_index = '0;
      if (func == FUNC_ALLOC) begin
         // lazy link of the next untouched block happens even on an empty pool
         if (pool_linked < pool_size) begin
            pool_next[pool_linked[IDX_W-1:0]] = pool_linked + 1'b1;
            pool_linked = pool_linked + 1'b1;
         end
         if (pool_free != 0) begin
            res.alloc_index = pool_head;
            pool_free = pool_free - 1'b1;
            if (pool_free == 0) begin
               pool_head = '0;
            end else begin
               succ = pool_next[pool_head];
               pool_head = (succ < pool_size) ? succ[IDX_W-1:0] : '0;
            end
         end else begin
            res.status = STATUS_EMPTY;
         end
      end else if (cnt_type'(index) >= pool_size) begin
         res.status = STATUS_RANGE;
      end else if (pool_free >= pool_size) begin
         res.status = STATUS_FULL;
      end else begin
         pool_next[index] = (pool_free == 0) ? pool_size : cnt_type'(pool_head);
         pool_head = index;
         pool_free = pool_free + 1'b1;
      end
      res.free_count = pool_free;
      return res;
   endfunction

   task automatic issue_op(input func_type func, input idx_type index, input logic typed,
                           input pool_result_type typed_res, output pool_result_type res);
      int unsigned gap;
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_func        <= func;
      req_block_index <= index;
      do @(posedge clock); while (busy);
      res = pool_apply(func, index);
      results_due.push_back(typed ? typed_res : res);
   endtask

   // pool must be quiet before the count is rewritten
   task automatic write_pool_size(input cnt_type value);
      start <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (value == 0)
         pool_size = 11'd1;
      else if (value > cnt_type'(POOL_MAX))
         pool_size = cnt_type'(POOL_MAX);
      else
         pool_size = value;
      pool_head   = '0;
      pool_free   = pool_size;
      pool_linked = '0;
      held_blocks.delete();
   endtask

   always @(posedge clock) begin
      pool_result_type want;
      if (!reset && rsp_valid) begin
         if (results_due.size() == 0) begin
            $error("result with none outstanding: status %0d, alloc_index %0d, free_count %0d",
                   rsp_status, rsp_alloc_index, rsp_free_count);
            mismatches++;
         end else begin
            want = results_due.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatches++;
            end
            if (rsp_alloc_index !== want.alloc_index) begin
               $error("alloc_index: expected %0d, got %0d", want.alloc_index, rsp_alloc_index);
               mismatches++;
            end
            if (rsp_free_count !== want.free_count) begin
               $error("free_count: expected %0d, got %0d", want.free_count, rsp_free_count);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      row_type         row;
      pool_result_type got;
      func_type        func;
      idx_type         index;
      cnt_type         size;
      int unsigned     roll;
      int unsigned     pick;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_OPS[n]) begin
         row = DIRECTED_OPS[n];
         if (row.kind == ROW_CSR)
            write_pool_size(row.csr_value);
         else
            issue_op(row.func, row.index, row.typed,
                     '{row.status, row.alloc_index, row.free_count}, got);
      end

      for (int phase = 0; phase < 8; phase++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: size = cnt_type'($urandom_range(1, 16));
            6, 7:             size = cnt_type'($urandom_range(17, 300));
            8:                size = cnt_type'(POOL_MAX);
            default:          size = cnt_type'($urandom_range(0, 2047));
         endcase
         write_pool_size(size);
         no_gaps = ($urandom_range(0, 3) == 0);
         repeat (100) begin
            roll  = $urandom_range(0, 99);
            index = idx_type'($urandom_range(0, 1023));
            if (roll < 50 || (held_blocks.size() == 0 && roll < 85)) begin
               func = FUNC_ALLOC;
            end else if (roll < 85) begin
               // well-formed free of a block handed out earlier
               func  = FUNC_FREE;
               pick  = $urandom_range(0, held_blocks.size() - 1);
               index = held_blocks[pick];
               held_blocks.delete(pick);
            end else if (roll < 93) begin
               func = FUNC_FREE;
            end else begin
               // in range but possibly a double free or a block never handed out
               func  = FUNC_FREE;
               index = idx_type'($urandom_range(0, pool_size - 1));
            end
            issue_op(func, index, 1'b0, '0, got);
            if (func == FUNC_ALLOC && got.status == STATUS_OK)
               held_blocks.push_back(got.alloc_index);
         end
      end

      start <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

[fixed_block_pool_allocator.f]
+incdir+sv
sv/fbpa_pkg.sv
sv/fbpa_ram.sv
sv/fixed_block_pool_allocator.sv
verif/tb_top.sv
